@@ hdl/cis_pkg.sv @@
// Package for the cubic inverse secant solver.
// Holds widths, register indexes, status codes, sequencer states and a saturation helper.
// No dependencies.
package cis_pkg;

    localparam int CoefW      = 32;
    localparam int GuessW     = 26;
    localparam int PrecW      = 25;
    localparam int TargetW    = 23;
    localparam int StatusW    = 2;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 32;
    localparam int DivNumW    = 64;
    localparam int DivDenW    = 33;
    localparam int DivergeMul = 1000;
    localparam int PolyOrderDef = 3;
    localparam int MaxIterDef   = 32;

    localparam logic [CfgIdxW-1:0] RegCoef0  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegCoef1  = 3'd1;
    localparam logic [CfgIdxW-1:0] RegCoef2  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegCoef3  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegGuess0 = 3'd4;
    localparam logic [CfgIdxW-1:0] RegGuess1 = 3'd5;
    localparam logic [CfgIdxW-1:0] RegPrec   = 3'd6;

    localparam logic [StatusW-1:0] StConverged = 2'd0;
    localparam logic [StatusW-1:0] StDiverged  = 2'd1;
    localparam logic [StatusW-1:0] StFailed    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_EV_INIT, S_EV_MUL, S_EV_ADD, S_EV_F, S_DEN,
        S_PROD, S_DIV_GO, S_DIV_WAIT, S_UPD, S_SEP, S_FIN
    } t_state;

    typedef struct packed {
        logic busy;
        logic div_start;
        logic use_step_ops;
    } t_ctrl;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

@@ hdl/cis_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Uses cis_pkg for operand widths.
module cis_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cis_pkg::DivNumW-1:0] i_num,
    input  logic [cis_pkg::DivDenW-1:0] i_den,
    output logic [cis_pkg::DivNumW-1:0] o_quot,
    output logic                        o_done
);
    import cis_pkg::*;

    localparam int CntW = $clog2(DivNumW + 1);

    logic [DivNumW-1:0] r_num, r_quot;
    logic [DivDenW-1:0] r_den;
    logic [DivDenW:0]   r_rem;
    logic [CntW-1:0]    r_cnt;
    logic               r_run, r_done;
    logic [DivDenW+1:0] trial;
    logic [DivDenW:0]   shifted;

    always_comb begin
        shifted = {r_rem[DivDenW-1:0], r_num[DivNumW-1]};
        trial   = {1'b0, shifted} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_cnt  <= CntW'(DivNumW);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_run) begin
                r_num <= {r_num[DivNumW-2:0], 1'b0};
                if (!trial[DivDenW+1]) begin
                    r_rem  <= trial[DivDenW:0];
                    r_quot <= {r_quot[DivNumW-2:0], 1'b1};
                end else begin
                    r_rem  <= shifted;
                    r_quot <= {r_quot[DivNumW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

`ifndef ASSERT_OFF
    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_run)) else $error("done without run");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run && !i_start |=> r_run || o_done) else $error("run dropped early");
    a_cnt_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_cnt == '0) else $error("count not spent");
`endif

endmodule

@@ hdl/cubic_inverse_secant_solver.sv @@
// Top level of the cubic inverse secant solver: registers, sequencer, shared multiplier.
// Depends on cis_pkg and cis_divider.
//
// channel  direction  handshake                 payload
// command  in         start & !busy             i_target_value
// result   out        o_done strobe, 1 cycle    o_root_value, o_status
// config   in         i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// Each secant iteration evaluates the cubic by Horner's rule at two points on the shared
// multiplier, then runs the bit-serial divider; an item takes at most MAX_ITER iterations,
// and a zero denominator exits before the divide.
// Reset is synchronous and restores the register defaults.
// busy drops in the cycle of the result strobe; o_cfg_ready is low while busy.
module cubic_inverse_secant_solver #(
    parameter int POLY_ORDER = cis_pkg::PolyOrderDef,
    parameter int MAX_ITER   = cis_pkg::MaxIterDef
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [cis_pkg::TargetW-1:0] i_target_value,
    output logic                               o_done,
    output logic [cis_pkg::GuessW-1:0]         o_root_value,
    output logic [cis_pkg::StatusW-1:0]        o_status,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cis_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [cis_pkg::CfgDataW-1:0]       i_cfg_data
);
    import cis_pkg::*;

    localparam int IterW = $clog2(MAX_ITER + 1);

    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic signed [31:0]  r_coef [4];
    logic [GuessW-1:0]   r_g0, r_g1;
    logic [PrecW-1:0]    r_prec;

    logic signed [31:0]  r_x0, r_x1, r_y, r_acc, r_f0, r_f1;
    logic signed [66:0]  r_prod;
    logic signed [32:0]  r_den;
    logic [35:0]         r_maxsep;
    logic [IterW-1:0]    r_iter;
    logic [1:0]          r_k;
    logic                r_sel, r_neg;
    logic [StatusW-1:0]  r_stat;
    logic                r_done;
    logic [GuessW-1:0]   r_root;

    logic signed [32:0]  diff;
    logic [32:0]         sep;
    logic signed [33:0]  op_a;
    logic signed [32:0]  op_b;
    logic signed [66:0]  prod;
    logic [31:0]         mag_f1;
    logic [32:0]         mag_den;
    logic [DivNumW-1:0]  quot;
    logic                div_done;
    logic [32:0]         uq;
    logic signed [33:0]  q;
    logic signed [31:0]  nx;
    logic signed [31:0]  xsel;
    logic signed [47:0]  horner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= -32'sd40427061;
            r_coef[1] <= 32'sd72819671;
            r_coef[2] <= -32'sd41305506;
            r_coef[3] <= 32'sd8912699;
            r_g0      <= GuessW'(16777216);
            r_g1      <= GuessW'(17616077);
            r_prec    <= PrecW'(17);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                RegCoef0:  r_coef[0] <= i_cfg_data;
                RegCoef1:  r_coef[1] <= i_cfg_data;
                RegCoef2:  r_coef[2] <= i_cfg_data;
                RegCoef3:  r_coef[3] <= i_cfg_data;
                RegGuess0: r_g0      <= i_cfg_data[GuessW-1:0];
                RegGuess1: r_g1      <= i_cfg_data[GuessW-1:0];
                RegPrec:   r_prec    <= i_cfg_data[PrecW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = !ctrl.busy;

    always_comb begin
        diff    = 33'(r_x1) - 33'(r_x0);
        sep     = diff[32] ? 33'(-diff) : 33'(diff);
        mag_f1  = r_f1[31] ? 32'(-r_f1) : 32'(r_f1);
        mag_den = r_den[32] ? 33'(-r_den) : 33'(r_den);
        xsel    = r_sel ? r_x1 : r_x0;
        if (ctrl.use_step_ops) begin
            op_a = {1'b0, sep};
            op_b = {1'b0, mag_f1};
        end else begin
            op_a = 34'(r_acc);
            op_b = 33'(xsel);
        end
        prod   = op_a * op_b;
        horner = 48'(r_prod >>> 24) + 48'(r_coef[r_k - 2'd1]);
        uq     = (quot > DivNumW'(64'h1_0000_0000)) ? 33'h1_0000_0000 : quot[32:0];
        q      = r_neg ? -34'(uq) : 34'(uq);
        nx     = sat32(48'(r_x1) - 48'(q));
    end

    cis_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctrl.div_start),
        .i_num   (r_prod[DivNumW-1:0]),
        .i_den   (mag_den),
        .o_quot  (quot),
        .o_done  (div_done)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (start) n_state = S_CHECK;
            S_CHECK: begin
                if (sep <= 33'(r_prec)) n_state = S_FIN;
                else if (r_iter >= IterW'(MAX_ITER)) n_state = S_FIN;
                else n_state = S_EV_INIT;
            end
            S_EV_INIT:  n_state = S_EV_MUL;
            S_EV_MUL:   n_state = S_EV_ADD;
            S_EV_ADD:   n_state = (r_k == 2'd1) ? S_EV_F : S_EV_MUL;
            S_EV_F:     n_state = r_sel ? S_DEN : S_EV_INIT;
            S_DEN:      n_state = (r_f1 == r_f0) ? S_FIN : S_PROD;
            S_PROD:     n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: if (div_done) n_state = S_UPD;
            S_UPD:      n_state = S_SEP;
            S_SEP:      n_state = (36'(sep) > r_maxsep) ? S_FIN : S_CHECK;
            S_FIN:      n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl.busy         = (r_state != S_IDLE);
        ctrl.div_start    = (r_state == S_DIV_GO);
        ctrl.use_step_ops = (r_state == S_PROD);
    end

    assign busy = ctrl.busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_stat  <= StConverged;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_x0     <= 32'(r_g0);
                    r_x1     <= 32'(r_g1);
                    r_y      <= 32'(i_target_value);
                    r_maxsep <= 36'(r_g1 > r_g0 ? r_g1 - r_g0 : r_g0 - r_g1) * 36'(DivergeMul);
                    r_iter   <= '0;
                    r_stat   <= StConverged;
                end
                S_CHECK: begin
                    if (sep > 33'(r_prec)) begin
                        if (r_iter >= IterW'(MAX_ITER)) r_stat <= StFailed;
                        else r_iter <= r_iter + 1'b1;
                    end
                    r_sel <= 1'b0;
                end
                S_EV_INIT: begin
                    r_acc <= r_coef[POLY_ORDER];
                    r_k   <= 2'(POLY_ORDER);
                end
                S_EV_MUL: r_prod <= prod;
                S_EV_ADD: begin
                    r_acc <= sat32(horner);
                    r_k   <= r_k - 2'd1;
                end
                S_EV_F: begin
                    if (r_sel) r_f1 <= sat32(48'(r_acc) - 48'(r_y));
                    else r_f0 <= sat32(48'(r_acc) - 48'(r_y));
                    r_sel <= 1'b1;
                end
                S_DEN: begin
                    r_den <= 33'(r_f1) - 33'(r_f0);
                    if (r_f1 == r_f0) r_stat <= StFailed;
                end
                S_PROD: begin
                    r_prod <= prod;
                    r_neg  <= diff[32] ^ r_f1[31] ^ r_den[32];
                end
                S_UPD: begin
                    r_x0 <= r_x1;
                    r_x1 <= nx;
                end
                S_SEP: if (36'(sep) > r_maxsep) r_stat <= StDiverged;
                S_FIN: begin
                    r_done <= 1'b1;
                    if (r_stat != StConverged || r_x1 < 0) r_root <= '0;
                    else if (r_x1 > 32'sd67108863) r_root <= '1;
                    else r_root <= r_x1[GuessW-1:0];
                end
                default: ;
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_root_value = r_root;
    assign o_status     = r_stat;

`ifndef ASSERT_OFF
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_FIN) else $error("strobe without finish");
    a_fail_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != StConverged |-> o_root_value == '0) else $error("root on fail");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_status != 2'd3) else $error("bad status");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter <= IterW'(MAX_ITER)) else $error("iteration overrun");
`endif

endmodule
